// File: design/bmf_pkg.sv
// Shared types and constants of the 3x3 box mean filter.
package bmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_W      = 13;
    localparam int COLSUM_W   = 10;
    localparam int SUM_W      = 12;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(480);
    localparam logic [FW_W-1:0] FRAME_WIDTH_MAX    = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MAX   = FH_W'(MAX_HEIGHT);
    localparam logic [FW_W-1:0] FRAME_WIDTH_MIN    = FW_W'(3);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_MIN   = FH_W'(3);

    // Register indexes on the configuration port.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // sum / 9 == (sum * 3641) >> 15 for every sum up to 9 * 255.
    localparam logic [SUM_W-1:0] MEAN_RECIP = SUM_W'(3641);
    localparam int               MEAN_SHIFT = 15;
    localparam int               PROD_W     = 2 * SUM_W;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [COL_W-1:0] centre_col;
        logic [ROW_W-1:0] centre_row;
        logic             emit;
        logic             done;
    } tag_t;

    typedef struct packed {
        logic             frame_done;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic [PIX_W-1:0] mean_value;
    } result_t;

endpackage

// File: design/box_mean_3x3_filter_top.sv
// Top level of the 3x3 box mean filter: position counters, line store access and checks.
//
// Pixels enter on the s_ channel in raster order, one 8-bit grey value per request.
// Each pixel whose column and row are both at least two completes a 3x3 window and
// yields one request on the m_ channel: the truncated mean of the nine pixels and the
// coordinates of the window centre. Border positions give nothing. m_tlast marks the
// result for the last interior pixel of the frame.
// Throughput is one pixel per cycle while s_tready is high. A result reaches m_tvalid
// through these steps: the line store is read at the accepting edge, then the column
// sum is registered, then the window sum, then the multiply by the reciprocal of nine
// is done together with the write into the queue.
// Results wait in an eight-entry queue; s_tready drops only when the queue plus the
// requests in flight would fill it, so a stalled receiver holds off the sender
// and nothing is lost.
// frame_width (cfg_wr_data[10:0]) and frame_height are written on the cfg_ port; values
// outside 3..1024 and 3..4096 saturate. A write, like reset, restarts the position at
// row 0, column 0. Reset sets the size to 640 by 480 and empties the pipeline and queue.
// Line store contents are undefined until the first two rows of a frame pass.
module box_mean_3x3_filter_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,      // [7:0] pixel
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,      // [7:0] mean_value, [17:8] centre_col,
                                                       // [29:18] centre_row, [31:30] zero
    output logic                         m_tlast,      // frame_done
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_index,
    input  logic [bmf_pkg::CFG_W-1:0]    cfg_wr_data
);

    logic [bmf_pkg::FW_W-1:0]     frame_width_reg, frame_width_next;
    logic [bmf_pkg::FH_W-1:0]     frame_height_reg, frame_height_next;
    logic [bmf_pkg::COL_W-1:0]    col_reg, col_next;
    logic [bmf_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [bmf_pkg::FW_W-1:0]     w_eff;
    logic [bmf_pkg::FH_W-1:0]     h_eff;
    logic [bmf_pkg::COL_W-1:0]    col_last;
    logic [bmf_pkg::ROW_W-1:0]    row_last;
    logic                         accept;
    logic                         p1_valid_reg;
    bmf_pkg::tag_t                p1_tag_reg, tag_next;
    logic [bmf_pkg::COL_W-1:0]    p1_col_reg;
    logic [bmf_pkg::PIX_W-1:0]    p1_pix_reg;
    logic [2*bmf_pkg::PIX_W-1:0]  line_rd_data;
    logic                         push;
    bmf_pkg::result_t             push_data;
    bmf_pkg::result_t             head;
    logic [1:0]                   pipe_busy;
    logic [bmf_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [bmf_pkg::FIFO_CNT_W:0] pending;

    always_comb begin
        if (frame_width_reg < bmf_pkg::FRAME_WIDTH_MIN) begin
            w_eff = bmf_pkg::FRAME_WIDTH_MIN;
        end else if (frame_width_reg > bmf_pkg::FRAME_WIDTH_MAX) begin
            w_eff = bmf_pkg::FRAME_WIDTH_MAX;
        end else begin
            w_eff = frame_width_reg;
        end
        if (frame_height_reg < bmf_pkg::FRAME_HEIGHT_MIN) begin
            h_eff = bmf_pkg::FRAME_HEIGHT_MIN;
        end else if (frame_height_reg > bmf_pkg::FRAME_HEIGHT_MAX) begin
            h_eff = bmf_pkg::FRAME_HEIGHT_MAX;
        end else begin
            h_eff = frame_height_reg;
        end
    end

    assign col_last = bmf_pkg::COL_W'(w_eff - 1'b1);
    assign row_last = bmf_pkg::ROW_W'(h_eff - 1'b1);

    // Count the queue entries and every request that may still land in the queue.
    assign pending  = (bmf_pkg::FIFO_CNT_W + 1)'(fifo_count)
                    + (bmf_pkg::FIFO_CNT_W + 1)'(p1_valid_reg)
                    + (bmf_pkg::FIFO_CNT_W + 1)'(pipe_busy);
    assign s_tready = (pending < (bmf_pkg::FIFO_CNT_W + 1)'(bmf_pkg::FIFO_DEPTH));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                bmf_pkg::REG_FRAME_WIDTH: begin
                    frame_width_next = cfg_wr_data[bmf_pkg::FW_W-1:0];
                end
                bmf_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_next = cfg_wr_data;
                end
                default: begin
                    frame_width_next = frame_width_reg;
                end
            endcase
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg == col_last) begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bmf_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= bmf_pkg::FRAME_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            p1_valid_reg     <= 1'b0;
        end else begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            p1_valid_reg     <= accept;
        end
    end

    always_comb begin
        tag_next.centre_col = col_reg - 1'b1;
        tag_next.centre_row = row_reg - 1'b1;
        tag_next.emit       = (col_reg >= bmf_pkg::COL_W'(2)) && (row_reg >= bmf_pkg::ROW_W'(2));
        tag_next.done       = (col_reg == col_last) && (row_reg == row_last);
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_tag_reg <= tag_next;
            p1_col_reg <= col_reg;
            p1_pix_reg <= s_tdata;
        end
    end

    // Entry layout: upper byte two rows up, lower byte one row up. The write-back
    // lands in the cycle after the read, well before the column comes round again.
    bmf_line_mem u_line_mem (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_rd_data),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data ({line_rd_data[bmf_pkg::PIX_W-1:0], p1_pix_reg})
    );

    bmf_mean_pipe u_mean_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (p1_valid_reg),
        .in_tag     (p1_tag_reg),
        .top_pix    (line_rd_data[2*bmf_pkg::PIX_W-1:bmf_pkg::PIX_W]),
        .mid_pix    (line_rd_data[bmf_pkg::PIX_W-1:0]),
        .bot_pix    (p1_pix_reg),
        .push       (push),
        .result     (push_data),
        .busy_count (pipe_busy)
    );

    bmf_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head),
        .count     (fifo_count)
    );

    assign m_tdata = {2'b00, head.centre_row, head.centre_col, head.mean_value};
    assign m_tlast = head.frame_done;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (fifo_count < bmf_pkg::FIFO_CNT_W'(bmf_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= col_last)
        else $error("column counter beyond frame width");

    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (col_reg == '0) && (row_reg == '0))
        else $error("configuration write did not restart the frame");

    a_pipe_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted pixel did not enter the pipeline");

endmodule

// File: design/bmf_line_mem.sv
// Two-line pixel store: one entry per column holds the pixels of the two previous rows.
module bmf_line_mem (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [bmf_pkg::COL_W-1:0]   rd_addr,
    output logic [2*bmf_pkg::PIX_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [bmf_pkg::COL_W-1:0]   wr_addr,
    input  logic [2*bmf_pkg::PIX_W-1:0] wr_data
);

    logic [2*bmf_pkg::PIX_W-1:0] mem [bmf_pkg::MAX_WIDTH];
    logic [2*bmf_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bmf_mean_pipe.sv
// Column sums, window sum and divide-by-nine pipeline of the box mean filter.
module bmf_mean_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  bmf_pkg::tag_t                 in_tag,
    input  logic [bmf_pkg::PIX_W-1:0]     top_pix,
    input  logic [bmf_pkg::PIX_W-1:0]     mid_pix,
    input  logic [bmf_pkg::PIX_W-1:0]     bot_pix,
    output logic                          push,
    output bmf_pkg::result_t              result,
    output logic [1:0]                    busy_count
);

    logic                             p2_valid_reg, p2_valid_next;
    logic                             p3_valid_reg, p3_valid_next;
    bmf_pkg::tag_t                    p2_tag_reg;
    bmf_pkg::tag_t                    p3_tag_reg;
    logic [bmf_pkg::COLSUM_W-1:0]     p2_colsum_reg;
    logic [bmf_pkg::COLSUM_W-1:0]     cs1_reg;
    logic [bmf_pkg::COLSUM_W-1:0]     cs2_reg;
    logic [bmf_pkg::SUM_W-1:0]        p3_sum_reg;
    logic [bmf_pkg::SUM_W-1:0]        sum_next;
    logic [bmf_pkg::COLSUM_W-1:0]     colsum_next;
    logic [bmf_pkg::PROD_W-1:0]       product;

    assign colsum_next = bmf_pkg::COLSUM_W'(top_pix) + bmf_pkg::COLSUM_W'(mid_pix)
                       + bmf_pkg::COLSUM_W'(bot_pix);
    assign sum_next    = bmf_pkg::SUM_W'(p2_colsum_reg) + bmf_pkg::SUM_W'(cs1_reg)
                       + bmf_pkg::SUM_W'(cs2_reg);
    assign p2_valid_next = in_valid;
    assign p3_valid_next = p2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p2_valid_next;
            p3_valid_reg <= p3_valid_next;
        end
    end

    // The two previous column sums of the current row form the rest of the window.
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            p2_colsum_reg <= colsum_next;
            p2_tag_reg    <= in_tag;
        end
        if (p2_valid_reg) begin
            cs2_reg    <= cs1_reg;
            cs1_reg    <= p2_colsum_reg;
            p3_sum_reg <= sum_next;
            p3_tag_reg <= p2_tag_reg;
        end
    end

    assign product = p3_sum_reg * bmf_pkg::MEAN_RECIP;

    assign push              = p3_valid_reg && p3_tag_reg.emit;
    assign result.mean_value = product[bmf_pkg::MEAN_SHIFT +: bmf_pkg::PIX_W];
    assign result.centre_col = p3_tag_reg.centre_col;
    assign result.centre_row = p3_tag_reg.centre_row;
    assign result.frame_done = p3_tag_reg.done;
    assign busy_count        = {1'b0, p2_valid_reg} + {1'b0, p3_valid_reg};

endmodule

// File: design/bmf_out_fifo.sv
// Result queue that decouples the filter pipeline from the output channel.
module bmf_out_fifo (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  bmf_pkg::result_t                 push_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output bmf_pkg::result_t                 out_data,
    output logic [bmf_pkg::FIFO_CNT_W-1:0]   count
);

    bmf_pkg::result_t                    mem [bmf_pkg::FIFO_DEPTH];
    logic [bmf_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [bmf_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [bmf_pkg::FIFO_CNT_W-1:0]      count_reg, count_next;
    logic                                pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + bmf_pkg::FIFO_CNT_W'(push) - bmf_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
